@@ design/merging_priority_job_queue_assert.svh @@
`ifndef MERGING_PRIORITY_JOB_QUEUE_ASSERT_SVH
`define MERGING_PRIORITY_JOB_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MPJQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MPJQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

@@ design/mpjq_pkg.sv @@
package mpjq_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_POP = 1'b1;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_MERGED  = 3'd1;
  localparam logic [2:0] ST_DROPPED = 3'd2;
  localparam logic [2:0] ST_POPPED  = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] tile_x;
    logic signed [15:0] tile_z;
    logic        [3:0]  detail_level;
    logic        [23:0] urgency;
  } in_item_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic signed [15:0] out_tile_x;
    logic signed [15:0] out_tile_z;
    logic        [3:0]  out_detail_level;
    logic        [23:0] out_urgency;
    logic        [6:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic               vld;
    logic signed [15:0] tile_x;
    logic signed [15:0] tile_z;
    logic        [3:0]  detail;
    logic        [23:0] urgency;
  } slot_t;

  typedef struct packed {
    logic clr_en;
    logic load;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_done;
  } dp_sts_t;

endpackage

@@ design/mpjq_ram.sv @@
module mpjq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/mpjq_ctrl.sv @@
module mpjq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  mpjq_pkg::dp_sts_t   sts,
  output mpjq_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;
  logic   commit;

  assign commit   = (state_r == S_DONE) && (!out_vld_r || !out_stall);
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_vld_r;

  always_comb begin
    cmd.clr_en = (state_r == S_CLEAR);
    cmd.load   = (state_r == S_IDLE) && in_valid;
    cmd.commit = commit;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clr_done) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_SCAN;
      S_SCAN:  if (sts.scan_done) state_nxt = S_DONE;
      S_DONE:  if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  // hold the result beat until taken, replace it on commit
  always_comb begin
    out_vld_nxt = out_vld_r && out_stall;
    if (commit) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

endmodule

@@ design/mpjq_datapath.sv @@
module mpjq_datapath #(
  parameter int DEPTH = mpjq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mpjq_pkg::ctl_cmd_t   cmd,
  output mpjq_pkg::dp_sts_t    sts,
  input  mpjq_pkg::in_item_t   in_data,
  output mpjq_pkg::out_item_t  out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = $bits(mpjq_pkg::slot_t);
  localparam logic [CW-1:0] CNT_LAST = CW'(DEPTH - 1);
  localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);

  mpjq_pkg::in_item_t  item_r, item_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                iss_r, iss_nxt;
  logic                rvld_r;
  logic [AW-1:0]       ridx_r;
  logic                match_f_r, match_f_nxt;
  logic [AW-1:0]       match_idx_r, match_idx_nxt;
  mpjq_pkg::slot_t     match_slot_r, match_slot_nxt;
  logic                free_f_r, free_f_nxt;
  logic [AW-1:0]       free_idx_r, free_idx_nxt;
  logic                best_f_r, best_f_nxt;
  logic [AW-1:0]       best_idx_r, best_idx_nxt;
  mpjq_pkg::slot_t     best_slot_r, best_slot_nxt;
  logic [CW-1:0]       held_r, held_nxt;
  mpjq_pkg::out_item_t out_r, res;

  logic                we;
  logic [AW-1:0]       waddr;
  mpjq_pkg::slot_t     wslot;
  logic [SW-1:0]       wdata_w, rdata_w;
  mpjq_pkg::slot_t     rd;
  logic [CW-1:0]       occ;
  logic [CW+6:0]       occ_ext;

  mpjq_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata_w),
    .raddr (cnt_r[AW-1:0]),
    .rdata (rdata_w)
  );

  assign wdata_w = wslot;
  assign rd      = rdata_w;

  assign sts.clr_done  = (cnt_r == CNT_LAST);
  assign sts.scan_done = rvld_r && (ridx_r == IDX_LAST);

  // sweep: issue one read per cycle, fold each returning entry in the next cycle
  always_comb begin
    item_nxt       = item_r;
    cnt_nxt        = cnt_r;
    iss_nxt        = iss_r;
    match_f_nxt    = match_f_r;
    match_idx_nxt  = match_idx_r;
    match_slot_nxt = match_slot_r;
    free_f_nxt     = free_f_r;
    free_idx_nxt   = free_idx_r;
    best_f_nxt     = best_f_r;
    best_idx_nxt   = best_idx_r;
    best_slot_nxt  = best_slot_r;
    held_nxt       = held_r;

    if (cmd.load) begin
      item_nxt    = in_data;
      cnt_nxt     = '0;
      iss_nxt     = 1'b1;
      match_f_nxt = 1'b0;
      free_f_nxt  = 1'b0;
      best_f_nxt  = 1'b0;
      held_nxt    = '0;
    end else begin
      if (cmd.clr_en) begin
        cnt_nxt = (cnt_r == CNT_LAST) ? '0 : cnt_r + CW'(1);
      end else if (iss_r) begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CNT_LAST) begin
          iss_nxt = 1'b0;
        end
      end

      if (rvld_r) begin
        if (rd.vld) begin
          held_nxt = held_r + CW'(1);
          if (!match_f_r && rd.tile_x == item_r.tile_x && rd.tile_z == item_r.tile_z) begin
            match_f_nxt    = 1'b1;
            match_idx_nxt  = ridx_r;
            match_slot_nxt = rd;
          end
          // strict compare keeps the lowest slot on ties
          if (!best_f_r || rd.urgency < best_slot_r.urgency) begin
            best_f_nxt    = 1'b1;
            best_idx_nxt  = ridx_r;
            best_slot_nxt = rd;
          end
        end else if (!free_f_r) begin
          free_f_nxt   = 1'b1;
          free_idx_nxt = ridx_r;
        end
      end
    end
  end

  // result and table update for the finished sweep; clearing writes during the clear pass
  always_comb begin
    we    = cmd.clr_en;
    waddr = cnt_r[AW-1:0];
    wslot = '0;
    occ   = held_r;
    res   = '0;
    res.status = mpjq_pkg::ST_EMPTY;

    if (cmd.commit) begin
      case (item_r.kind)
        mpjq_pkg::KIND_ENQ: begin
          if (match_f_r) begin
            we           = 1'b1;
            waddr        = match_idx_r;
            wslot        = match_slot_r;
            if (item_r.detail_level < match_slot_r.detail) begin
              wslot.detail = item_r.detail_level;
            end
            if (item_r.urgency < match_slot_r.urgency) begin
              wslot.urgency = item_r.urgency;
            end
            res.status   = mpjq_pkg::ST_MERGED;
          end else if (free_f_r) begin
            we            = 1'b1;
            waddr         = free_idx_r;
            wslot.vld     = 1'b1;
            wslot.tile_x  = item_r.tile_x;
            wslot.tile_z  = item_r.tile_z;
            wslot.detail  = item_r.detail_level;
            wslot.urgency = item_r.urgency;
            occ           = held_r + CW'(1);
            res.status    = mpjq_pkg::ST_ADDED;
          end else begin
            res.status = mpjq_pkg::ST_DROPPED;
          end
        end
        mpjq_pkg::KIND_POP: begin
          if (best_f_r) begin
            we                   = 1'b1;
            waddr                = best_idx_r;
            wslot                = best_slot_r;
            wslot.vld            = 1'b0;
            occ                  = held_r - CW'(1);
            res.status           = mpjq_pkg::ST_POPPED;
            res.out_tile_x       = best_slot_r.tile_x;
            res.out_tile_z       = best_slot_r.tile_z;
            res.out_detail_level = best_slot_r.detail;
            res.out_urgency      = best_slot_r.urgency;
          end
        end
        default: res.status = mpjq_pkg::ST_EMPTY;
      endcase
    end
    occ_ext       = {7'd0, occ};
    res.occupancy = occ_ext[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      iss_r     <= 1'b0;
      rvld_r    <= 1'b0;
      match_f_r <= 1'b0;
      free_f_r  <= 1'b0;
      best_f_r  <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      iss_r     <= iss_nxt;
      rvld_r    <= iss_r;
      match_f_r <= match_f_nxt;
      free_f_r  <= free_f_nxt;
      best_f_r  <= best_f_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    ridx_r       <= cnt_r[AW-1:0];
    match_idx_r  <= match_idx_nxt;
    match_slot_r <= match_slot_nxt;
    free_idx_r   <= free_idx_nxt;
    best_idx_r   <= best_idx_nxt;
    best_slot_r  <= best_slot_nxt;
    held_r       <= held_nxt;
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  assign out_data = out_r;

endmodule

@@ design/merging_priority_job_queue.sv @@
// Each item sweeps the slot table, one RAM read per cycle, then commits its result. Only
// one item is in flight: a new item is taken only after the last one's result commits.
// The sweep over the single-port-read slot RAM sets this limit.
// A finished result waits in the output register while the next item is taken.
// After reset a clearing pass writes every slot empty; in_stall stays high until it ends.
`include "merging_priority_job_queue_assert.svh"

module merging_priority_job_queue #(
  parameter int QUEUE_DEPTH = mpjq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mpjq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mpjq_pkg::out_item_t out_data
);

  mpjq_pkg::ctl_cmd_t cmd;
  mpjq_pkg::dp_sts_t  sts;

  mpjq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpjq_datapath #(
    .DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .out_data (out_data)
  );

  `MPJQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
  `MPJQ_ASSERT_NEXT(a_commit_shows_result, clk, rst_n, cmd.commit, out_valid)
  `MPJQ_ASSERT_NOW(a_clear_excludes_work, clk, rst_n, cmd.clr_en, !cmd.load && !cmd.commit)
  `MPJQ_ASSERT_NOW(a_non_pop_zero_fields, clk, rst_n,
                   out_valid && out_data.status != mpjq_pkg::ST_POPPED,
                   out_data.out_tile_x == 16'sd0 && out_data.out_urgency == 24'd0)

endmodule
